>>> hw/rtl/kpsc_pkg.sv
// ----------------------------------------------------------------------------
// kpsc_pkg: shared types and constants of the keyed Polybius square
// Action and status codes, fill alphabet and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package kpsc_pkg;

    // Default side length of the square
    localparam int SIDE_DEF = 5;

    // Width of the offset register
    localparam int OFFSET_W = 3;

    // Key-end fill alphabet: A..Z without W
    localparam int FILL_LEN   = 25;
    localparam int FILL_IDX_W = $clog2(FILL_LEN);
    localparam logic [7:0] FILL_ALPHABET [FILL_LEN] = '{
        8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49,
        8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52,
        8'h53, 8'h54, 8'h55, 8'h56, 8'h58, 8'h59, 8'h5A
    };

    // Key letters: W folds into V
    localparam logic [7:0] CH_W = 8'h57;
    localparam logic [7:0] CH_V = 8'h56;

    // Configuration register indexes
    localparam int REG_INDEX_OFFSET = 0;

    typedef enum logic [2:0] {
        ACT_CLEAR  = 3'd0,
        ACT_KEY    = 3'd1,
        ACT_FILL   = 3'd2,
        ACT_ENCODE = 3'd3,
        ACT_DECODE = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_BADPOS = 2'd2
    } status_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear;
        logic key;
        logic fill_start;
        logic fill_step;
        logic load_enc;
        logic load_dec;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic fill_done;
    } dp_stat_t;

endpackage : kpsc_pkg

`default_nettype wire

>>> hw/rtl/kpsc_datapath.sv
// ----------------------------------------------------------------------------
// kpsc_datapath: square storage, comparators and result register
// Holds the square, fill count and fill index; searches all slots in
// parallel, appends letters and registers encode and decode results.
// ----------------------------------------------------------------------------
`default_nettype none

module kpsc_datapath #(
    parameter int SIDE = kpsc_pkg::SIDE_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire kpsc_pkg::dp_cmd_t             cmd,
    output kpsc_pkg::dp_stat_t                 stat,
    input  wire logic [kpsc_pkg::OFFSET_W-1:0] index_offset,
    input  wire logic [7:0]                    letter,
    input  wire logic [3:0]                    row_in,
    input  wire logic [3:0]                    col_in,
    output logic      [7:0]                    letter_out,
    output logic      [3:0]                    row_out,
    output logic      [3:0]                    col_out,
    output logic      [1:0]                    status
);
    import kpsc_pkg::*;

    localparam int CELLS = SIDE * SIDE;
    localparam int IDX_W = $clog2(CELLS);
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int POS_W = $clog2(SIDE);

    logic [7:0]            square_reg [CELLS];
    logic [CNT_W-1:0]      fill_count_reg;
    logic [CNT_W-1:0]      fill_count_next;
    logic [FILL_IDX_W-1:0] fill_idx_reg;
    logic [FILL_IDX_W-1:0] fill_idx_next;

    logic [7:0]            letter_out_reg;
    logic [3:0]            row_out_reg;
    logic [3:0]            col_out_reg;
    status_t               status_reg;

    logic [7:0]            key_ch;
    logic [7:0]            search_ch;
    logic [CELLS-1:0]      hit;
    logic                  present;
    logic                  full;
    logic                  append;
    logic [POS_W-1:0]      hit_row;
    logic [POS_W-1:0]      hit_col;

    logic                  row_ge;
    logic                  col_ge;
    logic [3:0]            dec_row;
    logic [3:0]            dec_col;
    logic                  in_range;
    logic [IDX_W-1:0]      dec_idx;
    logic                  dec_ok;

    // Pick the character to look up
    assign key_ch    = (letter == CH_W) ? CH_V : letter;
    assign search_ch = cmd.fill_step ? FILL_ALPHABET[fill_idx_reg]
                     : (cmd.key ? key_ch : letter);

    // Compare every filled slot against the search character
    always_comb
    begin
        for (int i = 0; i < CELLS; i++)
        begin
            hit[i] = (CNT_W'(i) < fill_count_reg) && (square_reg[i] == search_ch);
        end
    end

    assign present = |hit;
    assign full    = (fill_count_reg == CNT_W'(CELLS));
    assign append  = (cmd.key || cmd.fill_step) && !present && !full;

    // Turn the lowest hit into row and column
    always_comb
    begin
        hit_row = '0;
        hit_col = '0;
        for (int i = CELLS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                hit_row = POS_W'(i / SIDE);
                hit_col = POS_W'(i % SIDE);
            end
        end
    end

    // Remove the offset and check the decode position
    assign row_ge   = (row_in >= 4'(index_offset));
    assign col_ge   = (col_in >= 4'(index_offset));
    assign dec_row  = row_in - 4'(index_offset);
    assign dec_col  = col_in - 4'(index_offset);
    assign in_range = row_ge && col_ge && (dec_row < 4'(SIDE)) && (dec_col < 4'(SIDE));
    assign dec_idx  = IDX_W'(dec_row[POS_W-1:0]) * IDX_W'(SIDE) + IDX_W'(dec_col[POS_W-1:0]);
    assign dec_ok   = in_range && (CNT_W'(dec_idx) < fill_count_reg);

    // Next fill count and fill index
    always_comb
    begin
        fill_count_next = fill_count_reg;
        if (cmd.clear)
        begin
            fill_count_next = '0;
        end
        else if (append)
        begin
            fill_count_next = fill_count_reg + CNT_W'(1);
        end

        fill_idx_next = fill_idx_reg;
        if (cmd.fill_start)
        begin
            fill_idx_next = '0;
        end
        else if (cmd.fill_step)
        begin
            fill_idx_next = fill_idx_reg + FILL_IDX_W'(1);
        end
    end

    // Hold fill count and fill index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            fill_idx_reg   <= '0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            fill_idx_reg   <= fill_idx_next;
        end
    end

    // Write the appended letter into the next free slot
    always_ff @(posedge clk)
    begin
        if (append)
        begin
            square_reg[fill_count_reg[IDX_W-1:0]] <= search_ch;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_enc)
        begin
            letter_out_reg <= '0;
            if (present)
            begin
                row_out_reg <= 4'(hit_row) + 4'(index_offset);
                col_out_reg <= 4'(hit_col) + 4'(index_offset);
                status_reg  <= ST_OK;
            end
            else
            begin
                row_out_reg <= '0;
                col_out_reg <= '0;
                status_reg  <= ST_ABSENT;
            end
        end
        else if (cmd.load_dec)
        begin
            row_out_reg <= '0;
            col_out_reg <= '0;
            if (dec_ok)
            begin
                letter_out_reg <= square_reg[dec_idx];
                status_reg     <= ST_OK;
            end
            else
            begin
                letter_out_reg <= '0;
                status_reg     <= ST_BADPOS;
            end
        end
    end

    assign stat.fill_done = (fill_idx_reg == FILL_IDX_W'(FILL_LEN - 1)) || full;

    assign letter_out = letter_out_reg;
    assign row_out    = row_out_reg;
    assign col_out    = col_out_reg;
    assign status     = status_reg;

    // The square never holds more letters than it has slots
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CNT_W'(CELLS))
        else $error("fill count beyond square size");

    // A clear empties the square on the next cycle
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> fill_count_reg == '0)
        else $error("fill count not zero after clear");

    // Letters are unique among the filled slots
    a_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit))
        else $error("duplicate letter in square");

endmodule : kpsc_datapath

`default_nettype wire

>>> hw/rtl/kpsc_ctrl.sv
// ----------------------------------------------------------------------------
// kpsc_ctrl: sequencing of the keyed Polybius square
// Accepts input beats, issues datapath commands, runs the key-end fill
// and tracks the output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module kpsc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         action,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output kpsc_pkg::dp_cmd_t       cmd,
    input  wire kpsc_pkg::dp_stat_t stat
);
    import kpsc_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_FILL
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    accept;
    action_t act;

    assign act      = action_t'(action);
    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // Decode the accepted beat into datapath commands, or step a running fill
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        if (state_reg == S_FILL)
        begin
            cmd.fill_step = 1'b1;
            if (stat.fill_done)
            begin
                state_next = S_IDLE;
            end
        end
        else if (accept)
        begin
            case (act)
                ACT_CLEAR:  cmd.clear    = 1'b1;
                ACT_KEY:    cmd.key      = 1'b1;
                ACT_FILL:
                begin
                    cmd.fill_start = 1'b1;
                    state_next     = S_FILL;
                end
                ACT_ENCODE: cmd.load_enc = 1'b1;
                ACT_DECODE: cmd.load_dec = 1'b1;
                default:    cmd          = '0;
            endcase
        end
    end

    // Raise the output beat on a loaded result, drop it when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_enc || cmd.load_dec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // No input beat is taken while the fill runs
    a_fill_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FILL |-> !accept)
        else $error("input accepted during fill");

    // A result is never loaded over one that waits untaken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !(cmd.load_enc || cmd.load_dec))
        else $error("pending result overwritten");

    // A fill start always leads into the fill state
    a_fill_enter: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_start |=> state_reg == S_FILL)
        else $error("fill did not start");

endmodule : kpsc_ctrl

`default_nettype wire

>>> hw/rtl/keyed_polybius_square_cipher.sv
// ----------------------------------------------------------------------------
// keyed_polybius_square_cipher: keyed 5x5 Polybius square
// Top level with stream ports, the APB offset register and the
// controller and datapath instances.
// ----------------------------------------------------------------------------
// Clear, key letter, encode and decode run without a wait state: the square sits
// in flip-flops and all slots are compared with the letter at once, and
// encode and decode results land in an output register. A new beat is taken
// while a result waits only if that result is taken in the same cycle. The
// key-end fill walks the 25-letter alphabet one letter per cycle through the
// same comparators, so that action holds the input until the alphabet is
// walked or the square is full. Configuration writes of index_offset at
// address 0 should be made while no beat is in progress.
`default_nettype none

module keyed_polybius_square_cipher #(
    parameter int SIDE = kpsc_pkg::SIDE_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] letter, [11:8] row_in, [15:12] col_in
    input  wire logic [15:0] s_axis_tdata,
    // [2:0] action
    input  wire logic [2:0]  s_axis_tuser,

    // Output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] letter_out, [11:8] row_out, [15:12] col_out
    output logic      [15:0] m_axis_tdata,
    // [1:0] status
    output logic      [1:0]  m_axis_tuser,

    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import kpsc_pkg::*;

    logic [OFFSET_W-1:0] index_offset_reg;
    logic                cfg_write;
    logic                cfg_hit;
    dp_cmd_t             cmd;
    dp_stat_t            stat;
    logic [7:0]          letter_out;
    logic [3:0]          row_out;
    logic [3:0]          col_out;
    logic [1:0]          status;

    // Register file: index_offset only
    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[2] == 1'(REG_INDEX_OFFSET));
    assign cfg_write = psel && penable && pwrite && pready && cfg_hit;
    assign prdata    = cfg_hit ? 32'(index_offset_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_offset_reg <= '0;
        end
        else if (cfg_write)
        begin
            index_offset_reg <= pwdata[OFFSET_W-1:0];
        end
    end

    kpsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .action    (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    kpsc_datapath #(
        .SIDE (SIDE)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .index_offset (index_offset_reg),
        .letter       (s_axis_tdata[7:0]),
        .row_in       (s_axis_tdata[11:8]),
        .col_in       (s_axis_tdata[15:12]),
        .letter_out   (letter_out),
        .row_out      (row_out),
        .col_out      (col_out),
        .status       (status)
    );

    // Pack the result beat
    assign m_axis_tdata = {col_out, row_out, letter_out};
    assign m_axis_tuser = status;

endmodule : keyed_polybius_square_cipher

`default_nettype wire

>>> dv/kpsc_check_pkg.sv
// ----------------------------------------------------------------------------
// kpsc_check_pkg: result tracking for the keyed Polybius square test
// Holds a local copy of the square, its fill count and the offset register.
// Accepted command beats update that copy and queue the result they cause.
// Result beats are checked field by field against the oldest queued result.
// ----------------------------------------------------------------------------
package kpsc_check_pkg;

    import kpsc_pkg::*;

    localparam int CELLS = SIDE_DEF * SIDE_DEF;

    // One result beat: tdata fields plus the tuser status
    typedef struct packed {
        logic [7:0] letter;
        logic [3:0] row;
        logic [3:0] col;
        status_t    status;
    } cipher_result_t;

    class cipher_tracker;
        logic [7:0]          key_square [CELLS];
        int                  square_fill;
        logic [OFFSET_W-1:0] offset;
        cipher_result_t      pending_results [$];
        int                  errors;

        function new();
            square_fill = 0;
            offset      = '0;
            errors      = 0;
        endfunction

        // Return the slot holding ch among the filled slots, or -1
        function int locate(logic [7:0] ch);
            for (int i = 0; i < square_fill; i++) begin
                if (key_square[i] == ch) begin
                    return i;
                end
            end
            return -1;
        endfunction

        // Append ch unless it is already present or the square is full
        function void append_letter(logic [7:0] ch);
            if (square_fill < CELLS && locate(ch) < 0) begin
                key_square[square_fill] = ch;
                square_fill++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Update the square for one accepted command beat, queue its result
        function void take_beat(logic [2:0] act, logic [7:0] ch,
                                logic [3:0] row_in, logic [3:0] col_in);
            int             r;
            int             c;
            int             slot;
            cipher_result_t res;
            logic [7:0]     key_ch;

            res = '0;
            case (act)
                ACT_CLEAR: begin
                    square_fill = 0;
                end
                ACT_KEY: begin
                    key_ch = (ch == CH_W) ? CH_V : ch;
                    append_letter(key_ch);
                end
                ACT_FILL: begin
                    for (int i = 0; i < FILL_LEN && square_fill < CELLS; i++) begin
                        append_letter(FILL_ALPHABET[i]);
                    end
                end
                ACT_ENCODE: begin
                    // W is looked up as it is, so it never matches a folded key
                    slot = locate(ch);
                    if (slot < 0) begin
                        res.status = ST_ABSENT;
                    end
                    else begin
                        res.row    = 4'(slot / SIDE_DEF + int'(offset));
                        res.col    = 4'(slot % SIDE_DEF + int'(offset));
                        res.status = ST_OK;
                    end
                    pending_results.push_back(res);
                end
                ACT_DECODE: begin
                    r = int'(row_in) - int'(offset);
                    c = int'(col_in) - int'(offset);
                    if (r < 0 || r >= SIDE_DEF || c < 0 || c >= SIDE_DEF ||
                        r * SIDE_DEF + c >= square_fill) begin
                        res.status = ST_BADPOS;
                    end
                    else begin
                        res.letter = key_square[r * SIDE_DEF + c];
                        res.status = ST_OK;
                    end
                    pending_results.push_back(res);
                end
                default: begin
                    // unknown codes are dropped by the block
                end
            endcase
        endfunction

        function void compare_field(string field, int expv, int got);
            if (expv != got) begin
                $error("%s mismatch: expected 'h%0h, got 'h%0h", field, expv, got);
                errors++;
            end
        endfunction

        // Check one accepted result beat against the oldest queued result
        function void match_result(logic [7:0] letter, logic [3:0] row,
                                   logic [3:0] col, logic [1:0] status);
            cipher_result_t exp_res;

            if (pending_results.size() == 0) begin
                $error("result beat with nothing pending: letter_out 'h%0h row_out %0d col_out %0d status %0d",
                       letter, row, col, status);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            compare_field("letter_out", exp_res.letter, letter);
            compare_field("row_out", exp_res.row, row);
            compare_field("col_out", exp_res.col, col);
            compare_field("status", exp_res.status, status);
        endfunction
    endclass

endpackage : kpsc_check_pkg

>>> dv/keyed_polybius_square_cipher_test.sv
// ----------------------------------------------------------------------------
// keyed_polybius_square_cipher_test: stream and register test of the cipher
// A directed run covers W folding, duplicate and odd-byte key letters, full
// squares, absent letters, bad and unfilled positions and unknown commands.
// Random key sessions with encode and decode traffic then run under several
// offsets, with random idling on both streams, and every result is checked.
// ----------------------------------------------------------------------------
module keyed_polybius_square_cipher_test;

    timeunit 1ns;
    timeprecision 1ps;

    import kpsc_pkg::*;
    import kpsc_check_pkg::*;

    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         SETTLE_CYCLES = 32;
    localparam int         PHASE_ITEMS   = 100;
    localparam int         NUM_PHASES    = 6;
    localparam logic [2:0] ACT_CODE_MAX  = 3'h7;
    localparam logic [2:0] OFFSET_ADDR   = 3'(4 * REG_INDEX_OFFSET);

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [7:0] letter, [11:8] row_in, [15:12] col_in
    logic [2:0]  s_axis_tuser;   // [2:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [7:0] letter_out, [11:8] row_out, [15:12] col_out
    logic [1:0]  m_axis_tuser;   // [1:0] status
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cipher_tracker book;
    int            src_idle_pct;
    int            dst_idle_pct;
    int            beats_sent;
    int            items_done;
    int            cycle_count;
    int            phase_offsets [NUM_PHASES] = '{4, 0, 2, 4, 1, 3};

    keyed_polybius_square_cipher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stall the result stream at random
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Check each result beat
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            book.match_result(m_axis_tdata[7:0], m_axis_tdata[11:8],
                              m_axis_tdata[15:12], m_axis_tuser);
        end
    end

    // Receiver idles more first, then the sender, then neither
    function automatic void pick_idle_mode();
        if (beats_sent < 220) begin
            src_idle_pct = 36;
            dst_idle_pct = 48;
        end
        else if (beats_sent < 440) begin
            src_idle_pct = 48;
            dst_idle_pct = 36;
        end
        else begin
            src_idle_pct = 0;
            dst_idle_pct = 0;
        end
    endfunction

    // Offer one command beat and hold it until accepted
    task automatic send_beat(input logic [2:0] act, input logic [7:0] ch,
                             input logic [3:0] row, input logic [3:0] col);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {col, row, ch};
        s_axis_tuser  <= act;
        @(posedge clk);
        while (!s_axis_tready) begin
            @(posedge clk);
        end
        book.take_beat(act, ch, row, col);
        beats_sent++;
        if (act <= ACT_DECODE) begin
            items_done++;
        end
        pick_idle_mode();
    endtask

    // Drop valid, drain pending results and let a key-end fill finish
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (book.pending() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the offset register, then read it back
    task automatic write_offset(input int value);
        logic [31:0] readback;

        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= OFFSET_ADDR;
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        book.offset = OFFSET_W'(value);
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== 32'(value)) begin
            $error("index_offset mismatch: expected 'h%0h, got 'h%0h", value, readback);
            book.errors++;
        end
    endtask

    // Mostly capitals, some W, the rest any byte
    function automatic logic [7:0] pick_letter();
        int roll;

        roll = $urandom_range(99);
        if (roll < 55) begin
            return 8'($urandom_range(FILL_ALPHABET[0], FILL_ALPHABET[FILL_LEN-1]));
        end
        else if (roll < 65) begin
            return CH_W;
        end
        return 8'($urandom);
    endfunction

    // Mostly a valid row or column under the current offset
    function automatic logic [3:0] pick_pos();
        if ($urandom_range(99) < 80) begin
            return 4'(int'(book.offset) + $urandom_range(0, SIDE_DEF - 1));
        end
        return 4'($urandom_range(0, 15));
    endfunction

    // One key session with lookups, or a burst of raw noise
    task automatic run_session();
        int nkeys;
        int nuse;
        int roll;

        if ($urandom_range(99) < 15) begin
            repeat (8) begin
                send_beat(3'($urandom_range(0, ACT_CODE_MAX)), 8'($urandom),
                          4'($urandom), 4'($urandom));
            end
            return;
        end
        send_beat(ACT_CLEAR, 8'($urandom), 4'($urandom), 4'($urandom));
        nkeys = ($urandom_range(99) < 20) ? $urandom_range(20, 30) : $urandom_range(0, 10);
        repeat (nkeys) begin
            send_beat(ACT_KEY, pick_letter(), 4'($urandom), 4'($urandom));
        end
        if ($urandom_range(99) < 75) begin
            send_beat(ACT_FILL, 8'($urandom), 4'($urandom), 4'($urandom));
        end
        nuse = $urandom_range(4, 16);
        repeat (nuse) begin
            roll = $urandom_range(99);
            if (roll < 45) begin
                send_beat(ACT_ENCODE, pick_letter(), 4'($urandom), 4'($urandom));
            end
            else if (roll < 90) begin
                send_beat(ACT_DECODE, 8'($urandom), pick_pos(), pick_pos());
            end
            else begin
                send_beat(ACT_KEY, pick_letter(), 4'($urandom), 4'($urandom));
            end
        end
    endtask

    initial
    begin
        book          = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        beats_sent    = 0;
        items_done    = 0;
        pick_idle_mode();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: W folding, duplicates, odd bytes, misses and bad positions
        send_beat(ACT_CLEAR, 8'h00, 4'h0, 4'h0);
        send_beat(ACT_KEY, CH_W, 4'h0, 4'h0);
        send_beat(ACT_KEY, CH_V, 4'h0, 4'h0);
        send_beat(ACT_KEY, 8'h00, 4'h0, 4'h0);
        send_beat(ACT_KEY, 8'hFF, 4'hF, 4'hF);
        send_beat(ACT_KEY, FILL_ALPHABET[10], 4'h0, 4'h0);
        send_beat(ACT_ENCODE, CH_W, 4'h0, 4'h0);
        send_beat(ACT_ENCODE, CH_V, 4'h0, 4'h0);
        send_beat(ACT_ENCODE, 8'h00, 4'h0, 4'h0);
        send_beat(ACT_ENCODE, 8'hFF, 4'h0, 4'h0);
        send_beat(ACT_ENCODE, FILL_ALPHABET[16], 4'h0, 4'h0);
        send_beat(ACT_DECODE, 8'h00, 4'h0, 4'h0);
        send_beat(ACT_DECODE, 8'h00, 4'h9, 4'h9);
        send_beat(ACT_DECODE, 8'h00, 4'h0, 4'h4);
        send_beat(ACT_FILL, 8'h00, 4'h0, 4'h0);
        send_beat(ACT_ENCODE, FILL_ALPHABET[FILL_LEN-1], 4'h0, 4'h0);
        send_beat(ACT_DECODE, 8'h00, 4'h4, 4'h4);
        send_beat(ACT_KEY, FILL_ALPHABET[0], 4'h0, 4'h0);
        send_beat(3'(ACT_DECODE + 1), 8'hFF, 4'hF, 4'hF);
        send_beat(3'(ACT_DECODE + 2), 8'h00, 4'h0, 4'h0);
        send_beat(ACT_CODE_MAX, 8'h5A, 4'h1, 4'h2);
        send_beat(ACT_DECODE, 8'h00, 4'h0, 4'h1);
        send_beat(ACT_CLEAR, 8'h00, 4'h0, 4'h0);
        send_beat(ACT_DECODE, 8'h00, 4'h0, 4'h0);
        items_done = 0;

        // Random sessions, one offset per phase, block idle between phases
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            write_offset(phase_offsets[p]);
            while (items_done < (p + 1) * PHASE_ITEMS) begin
                run_session();
            end
        end
        settle();

        if (book.errors == 0 && book.pending() == 0) begin
            $display("RESULT: OK");
        end
        else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule : keyed_polybius_square_cipher_test
